@@ hw/rtl/tfm_pkg.sv @@
// ----------------------------------------------------------------------------
// tfm_pkg
// shared widths, register indexes and severity codes of the fault monitor
// ----------------------------------------------------------------------------
package tfm_pkg;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_LOSS_LEVEL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERSIST_SAMPLES       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BROWNOUT_LEVEL        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_LIMIT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OVERHEAT_LEVEL        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_CHARGE_LEVEL      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_CHARGE_LEVEL = 3'd6;

    // register reset values
    localparam logic [15:0]        VOLTAGE_LOSS_LEVEL_RST    = 16'd27500;
    localparam logic [7:0]         PERSIST_SAMPLES_RST       = 8'd10;
    localparam logic [15:0]        BROWNOUT_LEVEL_RST        = 16'd21000;
    localparam logic [7:0]         HEARTBEAT_LIMIT_RST       = 8'd2;
    localparam logic signed [11:0] OVERHEAT_LEVEL_RST        = 12'sd260;
    localparam logic [9:0]         LOW_CHARGE_LEVEL_RST      = 10'd300;
    localparam logic [9:0]         CRITICAL_CHARGE_LEVEL_RST = 10'd100;

    // severity codes
    typedef logic [2:0] severity_t;
    localparam severity_t SEV_NONE         = 3'd0;
    localparam severity_t SEV_VOLTAGE_LOSS = 3'd1;
    localparam severity_t SEV_LOW_CHARGE   = 3'd2;
    localparam severity_t SEV_CRITICAL     = 3'd3;
    localparam severity_t SEV_HEAT_BROWN   = 3'd4;
    localparam severity_t SEV_HEARTBEAT    = 3'd5;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

endpackage

@@ hw/rtl/telemetry_fault_monitor_top.sv @@
// ----------------------------------------------------------------------------
// telemetry_fault_monitor_top
// fault monitor for a telemetry sample stream
// ----------------------------------------------------------------------------
// usage
// - s_axis carries one telemetry sample per item, m_axis one result per item
//   holding the six fault flags, the echoed timestamp and a severity code
// - cfg_valid/cfg_ready write one threshold register at cfg_index; write
//   only while no item is in flight; indexes beyond the list are ignored
// - a result is registered: it is visible in the cycle after its sample is accepted
// - throughput: one item per cycle while results are taken; the state update
//   and the severity priority fit between the input handshake and the result register
// - when m_axis stalls the result register holds and s_axis_tready drops
//   until the result is taken; a result taken frees the register in the same
//   cycle, so a new sample can be accepted without a gap
// - reset clears all flags and run counters and loads the threshold defaults
// ----------------------------------------------------------------------------
module telemetry_fault_monitor_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tfm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tfm_pkg::CFG_DATA_W-1:0]   cfg_data,
    // sample stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // sample_time[31:0], bus_millivolts[47:32], charge_tenths[57:48],
    // temp_tenths[69:58], heartbeat_seen[70], zero[71]
    input  logic [tfm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // time_echo[31:0], voltage_loss_flag[32], brownout_flag[33],
    // overheat_flag[34], low_charge_flag[35], critical_charge_flag[36],
    // heartbeat_lost_flag[37], severity[40:38], zero[47:41]
    output logic [tfm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    // threshold registers
    logic [15:0]        voltage_loss_level_reg;
    logic [7:0]         persist_samples_reg;
    logic [15:0]        brownout_level_reg;
    logic [7:0]         heartbeat_limit_reg;
    logic signed [11:0] overheat_level_reg;
    logic [9:0]         low_charge_level_reg;
    logic [9:0]         critical_charge_level_reg;

    // monitor state
    logic       heartbeat_lost_reg,      heartbeat_lost_next;
    logic       brownout_latched_reg,    brownout_latched_next;
    logic       overheat_latched_reg,    overheat_latched_next;
    logic       voltage_loss_active_reg, voltage_loss_active_next;
    logic       low_charge_active_reg,   low_charge_active_next;
    logic       critical_latched_reg,    critical_latched_next;
    logic [7:0] missing_beat_count_reg,  missing_beat_count_next;
    logic [7:0] low_volt_run_reg,        low_volt_run_next;
    logic [7:0] good_volt_run_reg,       good_volt_run_next;

    // result register
    logic                            out_valid_reg;
    logic [tfm_pkg::OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    // unpacked sample
    logic [31:0]        sample_time;
    logic [15:0]        bus_millivolts;
    logic [9:0]         charge_tenths;
    logic signed [11:0] temp_tenths;
    logic               heartbeat_seen;

    logic               accept;
    logic               bus_low;
    logic [7:0]         persist_need;
    logic [7:0]         beat_need;
    logic [7:0]         low_run_inc;
    logic [7:0]         good_run_inc;
    logic [7:0]         beat_inc;
    tfm_pkg::severity_t severity;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign sample_time    = s_axis_tdata[31:0];
    assign bus_millivolts = s_axis_tdata[47:32];
    assign charge_tenths  = s_axis_tdata[57:48];
    assign temp_tenths    = $signed(s_axis_tdata[69:58]);
    assign heartbeat_seen = s_axis_tdata[70];

    // a zero run limit behaves as one
    assign persist_need = (persist_samples_reg == 8'd0) ? 8'd1 : persist_samples_reg;
    assign beat_need    = (heartbeat_limit_reg == 8'd0) ? 8'd1 : heartbeat_limit_reg;
    assign bus_low      = bus_millivolts < voltage_loss_level_reg;

    // saturating increments
    assign beat_inc     = (missing_beat_count_reg == tfm_pkg::COUNT_MAX)
                          ? tfm_pkg::COUNT_MAX : missing_beat_count_reg + 8'd1;
    assign low_run_inc  = (low_volt_run_reg == tfm_pkg::COUNT_MAX)
                          ? tfm_pkg::COUNT_MAX : low_volt_run_reg + 8'd1;
    assign good_run_inc = (good_volt_run_reg == tfm_pkg::COUNT_MAX)
                          ? tfm_pkg::COUNT_MAX : good_volt_run_reg + 8'd1;

    always_comb
    begin
        heartbeat_lost_next      = heartbeat_lost_reg;
        missing_beat_count_next  = missing_beat_count_reg;
        voltage_loss_active_next = voltage_loss_active_reg;
        low_volt_run_next        = low_volt_run_reg;
        good_volt_run_next       = good_volt_run_reg;

        // beat counter freezes once loss has latched
        if (!heartbeat_lost_reg)
        begin
            missing_beat_count_next = heartbeat_seen ? 8'd0 : beat_inc;
            if (missing_beat_count_next >= beat_need)
                heartbeat_lost_next = 1'b1;
        end

        brownout_latched_next = brownout_latched_reg || (bus_millivolts <= brownout_level_reg);
        overheat_latched_next = overheat_latched_reg || (temp_tenths >= overheat_level_reg);

        // both runs restart whenever the flag toggles
        if (!voltage_loss_active_reg)
        begin
            low_volt_run_next = bus_low ? low_run_inc : 8'd0;
            if (low_volt_run_next >= persist_need)
            begin
                voltage_loss_active_next = 1'b1;
                low_volt_run_next        = 8'd0;
                good_volt_run_next       = 8'd0;
            end
        end
        else
        begin
            good_volt_run_next = bus_low ? 8'd0 : good_run_inc;
            if (good_volt_run_next >= persist_need)
            begin
                voltage_loss_active_next = 1'b0;
                low_volt_run_next        = 8'd0;
                good_volt_run_next       = 8'd0;
            end
        end

        low_charge_active_next = charge_tenths <= low_charge_level_reg;
        critical_latched_next  = critical_latched_reg
                                 || (charge_tenths <= critical_charge_level_reg);

        priority if (heartbeat_lost_next)
            severity = tfm_pkg::SEV_HEARTBEAT;
        else if (overheat_latched_next || brownout_latched_next)
            severity = tfm_pkg::SEV_HEAT_BROWN;
        else if (critical_latched_next)
            severity = tfm_pkg::SEV_CRITICAL;
        else if (low_charge_active_next)
            severity = tfm_pkg::SEV_LOW_CHARGE;
        else if (voltage_loss_active_next)
            severity = tfm_pkg::SEV_VOLTAGE_LOSS;
        else
            severity = tfm_pkg::SEV_NONE;

        out_data_next = {7'd0,
                         severity,
                         heartbeat_lost_next,
                         critical_latched_next,
                         low_charge_active_next,
                         overheat_latched_next,
                         brownout_latched_next,
                         voltage_loss_active_next,
                         sample_time};
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voltage_loss_level_reg    <= tfm_pkg::VOLTAGE_LOSS_LEVEL_RST;
            persist_samples_reg       <= tfm_pkg::PERSIST_SAMPLES_RST;
            brownout_level_reg        <= tfm_pkg::BROWNOUT_LEVEL_RST;
            heartbeat_limit_reg       <= tfm_pkg::HEARTBEAT_LIMIT_RST;
            overheat_level_reg        <= tfm_pkg::OVERHEAT_LEVEL_RST;
            low_charge_level_reg      <= tfm_pkg::LOW_CHARGE_LEVEL_RST;
            critical_charge_level_reg <= tfm_pkg::CRITICAL_CHARGE_LEVEL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tfm_pkg::REG_VOLTAGE_LOSS_LEVEL:    voltage_loss_level_reg    <= cfg_data;
                tfm_pkg::REG_PERSIST_SAMPLES:       persist_samples_reg       <= cfg_data[7:0];
                tfm_pkg::REG_BROWNOUT_LEVEL:        brownout_level_reg        <= cfg_data;
                tfm_pkg::REG_HEARTBEAT_LIMIT:       heartbeat_limit_reg       <= cfg_data[7:0];
                tfm_pkg::REG_OVERHEAT_LEVEL:        overheat_level_reg        <= $signed(cfg_data[11:0]);
                tfm_pkg::REG_LOW_CHARGE_LEVEL:      low_charge_level_reg      <= cfg_data[9:0];
                tfm_pkg::REG_CRITICAL_CHARGE_LEVEL: critical_charge_level_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // monitor state, advanced once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heartbeat_lost_reg      <= 1'b0;
            brownout_latched_reg    <= 1'b0;
            overheat_latched_reg    <= 1'b0;
            voltage_loss_active_reg <= 1'b0;
            low_charge_active_reg   <= 1'b0;
            critical_latched_reg    <= 1'b0;
            missing_beat_count_reg  <= 8'd0;
            low_volt_run_reg        <= 8'd0;
            good_volt_run_reg       <= 8'd0;
        end
        else if (accept)
        begin
            heartbeat_lost_reg      <= heartbeat_lost_next;
            brownout_latched_reg    <= brownout_latched_next;
            overheat_latched_reg    <= overheat_latched_next;
            voltage_loss_active_reg <= voltage_loss_active_next;
            low_charge_active_reg   <= low_charge_active_next;
            critical_latched_reg    <= critical_latched_next;
            missing_beat_count_reg  <= missing_beat_count_next;
            low_volt_run_reg        <= low_volt_run_next;
            good_volt_run_reg       <= good_volt_run_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

endmodule

@@ verif/telemetry_fault_monitor_top_tb.sv @@
// ----------------------------------------------------------------------------
// telemetry_fault_monitor_top_tb
// self-checking bench for the telemetry fault monitor
// ----------------------------------------------------------------------------
// drives samples on s_axis and a scoreboard compares every m_axis result,
// field by field, with an in-bench model of the flags, run counters and
// severity priority. directed items probe the thresholds and the run rules;
// random traffic then runs with the latching faults kept out of reach, and
// finally every fault is latched in turn and traffic continues on top.
// sender gaps and receiver stalls vary from phase to phase
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module telemetry_fault_monitor_top_tb;

    localparam int CYCLE_LIMIT = 400000;

    localparam logic [tfm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // fields from the lowest bit up: stamp, bus, charge, temp, heartbeat
    typedef struct packed {
        logic        heartbeat;
        logic [11:0] temp;
        logic [9:0]  charge;
        logic [15:0] bus_mv;
        logic [31:0] stamp;
    } sample_t;

    // fields from the lowest bit up: stamp, six flags, severity
    typedef struct packed {
        tfm_pkg::severity_t sev;
        logic               beat_lost;
        logic               critical;
        logic               low_charge;
        logic               overheat;
        logic               brownout;
        logic               vloss;
        logic [31:0]        stamp;
    } report_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [tfm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tfm_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [tfm_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [tfm_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    telemetry_fault_monitor_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // thresholds as the block holds them
    logic [15:0]        cfg_vloss_level     = tfm_pkg::VOLTAGE_LOSS_LEVEL_RST;
    logic [7:0]         cfg_persist         = tfm_pkg::PERSIST_SAMPLES_RST;
    logic [15:0]        cfg_brownout_level  = tfm_pkg::BROWNOUT_LEVEL_RST;
    logic [7:0]         cfg_beat_limit      = tfm_pkg::HEARTBEAT_LIMIT_RST;
    logic signed [11:0] cfg_overheat_level  = tfm_pkg::OVERHEAT_LEVEL_RST;
    logic [9:0]         cfg_low_charge      = tfm_pkg::LOW_CHARGE_LEVEL_RST;
    logic [9:0]         cfg_critical_charge = tfm_pkg::CRITICAL_CHARGE_LEVEL_RST;

    // fault state
    logic       beat_lost     = 1'b0;
    logic       brownout_seen = 1'b0;
    logic       overheat_seen = 1'b0;
    logic       vloss_on      = 1'b0;
    logic       charge_low    = 1'b0;
    logic       critical_seen = 1'b0;
    logic [7:0] missed_beats  = '0;
    logic [7:0] low_run       = '0;
    logic [7:0] good_run      = '0;

    report_t pending_reports[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      send_gap_pct = 0;
    int      stall_pct = 0;
    int      burst_left = 0;
    bit      burst_low = 1'b0;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_reports.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    function automatic logic [7:0] bump(logic [7:0] count);
        return (count == tfm_pkg::COUNT_MAX) ? count : count + 8'd1;
    endfunction

    function automatic report_t step_monitor(sample_t s);
        report_t    r;
        logic [7:0] run_need;
        logic [7:0] beat_need;
        logic       is_low;
        // a zero run length behaves as one
        run_need  = (cfg_persist == 8'd0) ? 8'd1 : cfg_persist;
        beat_need = (cfg_beat_limit == 8'd0) ? 8'd1 : cfg_beat_limit;
        is_low    = s.bus_mv < cfg_vloss_level;

        if (!beat_lost)
        begin
            missed_beats = s.heartbeat ? 8'd0 : bump(missed_beats);
            if (missed_beats >= beat_need)
                beat_lost = 1'b1;
        end
        if (s.bus_mv <= cfg_brownout_level)
            brownout_seen = 1'b1;
        if ($signed(s.temp) >= cfg_overheat_level)
            overheat_seen = 1'b1;

        if (!vloss_on)
        begin
            low_run = is_low ? bump(low_run) : 8'd0;
            if (low_run >= run_need)
            begin
                vloss_on = 1'b1;
                low_run  = '0;
                good_run = '0;
            end
        end
        else
        begin
            good_run = is_low ? 8'd0 : bump(good_run);
            if (good_run >= run_need)
            begin
                vloss_on = 1'b0;
                low_run  = '0;
                good_run = '0;
            end
        end

        charge_low = s.charge <= cfg_low_charge;
        if (s.charge <= cfg_critical_charge)
            critical_seen = 1'b1;

        if (beat_lost)
            r.sev = tfm_pkg::SEV_HEARTBEAT;
        else if (overheat_seen || brownout_seen)
            r.sev = tfm_pkg::SEV_HEAT_BROWN;
        else if (critical_seen)
            r.sev = tfm_pkg::SEV_CRITICAL;
        else if (charge_low)
            r.sev = tfm_pkg::SEV_LOW_CHARGE;
        else if (vloss_on)
            r.sev = tfm_pkg::SEV_VOLTAGE_LOSS;
        else
            r.sev = tfm_pkg::SEV_NONE;

        r.stamp      = s.stamp;
        r.vloss      = vloss_on;
        r.brownout   = brownout_seen;
        r.overheat   = overheat_seen;
        r.low_charge = charge_low;
        r.critical   = critical_seen;
        r.beat_lost  = beat_lost;
        return r;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] seen);
        if (want !== seen)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
        end
    endfunction

    always @(posedge clk)
    begin
        report_t seen;
        report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = m_axis_tdata[$bits(report_t)-1:0];
            if (pending_reports.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, got %0h", $time, seen);
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("time_echo", want.stamp, seen.stamp);
                check_field("voltage_loss_flag", 32'(want.vloss), 32'(seen.vloss));
                check_field("brownout_flag", 32'(want.brownout), 32'(seen.brownout));
                check_field("overheat_flag", 32'(want.overheat), 32'(seen.overheat));
                check_field("low_charge_flag", 32'(want.low_charge), 32'(seen.low_charge));
                check_field("critical_charge_flag", 32'(want.critical), 32'(seen.critical));
                check_field("heartbeat_lost_flag", 32'(want.beat_lost), 32'(seen.beat_lost));
                check_field("severity", 32'(want.sev), 32'(seen.sev));
            end
        end
    end

    // valid is left high after the accept so the next item can follow directly
    task automatic send_sample(sample_t s);
        if ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, s};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_reports.insert(pending_reports.size(), step_monitor(s));
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(logic [tfm_pkg::CFG_IDX_W-1:0] idx,
                             logic [tfm_pkg::CFG_DATA_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        unique case (idx)
            tfm_pkg::REG_VOLTAGE_LOSS_LEVEL:    cfg_vloss_level     = value;
            tfm_pkg::REG_PERSIST_SAMPLES:       cfg_persist         = value[7:0];
            tfm_pkg::REG_BROWNOUT_LEVEL:        cfg_brownout_level  = value;
            tfm_pkg::REG_HEARTBEAT_LIMIT:       cfg_beat_limit      = value[7:0];
            tfm_pkg::REG_OVERHEAT_LEVEL:        cfg_overheat_level  = value[11:0];
            tfm_pkg::REG_LOW_CHARGE_LEVEL:      cfg_low_charge      = value[9:0];
            tfm_pkg::REG_CRITICAL_CHARGE_LEVEL: cfg_critical_charge = value[9:0];
            default: ;
        endcase
    endtask

    task automatic set_pace(int gap_pct, int hold_pct);
        send_gap_pct = gap_pct;
        stall_pct    = hold_pct;
    endtask

    function automatic sample_t make_sample(logic [15:0] bus, logic [9:0] chg,
                                            logic [11:0] temp, logic beat);
        sample_t s;
        s.stamp     = $urandom;
        s.bus_mv    = bus;
        s.charge    = chg;
        s.temp      = temp;
        s.heartbeat = beat;
        return s;
    endfunction

    // bus voltage comes in runs of low or good items so the persistence
    // counters get to the assert and clear points; without latching allowed
    // the brownout, overheat and critical levels sit at their extremes and
    // zero bus, zero charge and top temperature are kept out
    function automatic sample_t random_sample(bit allow_latch);
        sample_t     s;
        int unsigned floor_val;
        int unsigned good_floor;
        floor_val = allow_latch ? 0 : 1;
        if (burst_left == 0)
        begin
            burst_low  = 1'($urandom_range(1));
            burst_left = $urandom_range(1) ? $urandom_range(3, 1)
                                           : $urandom_range(cfg_persist + 2, 1);
        end
        burst_left--;
        good_floor = (cfg_vloss_level > floor_val) ? cfg_vloss_level : floor_val;
        s.stamp = $urandom;
        if ($urandom_range(19) == 0)
            s.bus_mv = 16'($urandom_range(16'hFFFF, floor_val));
        else if (burst_low && cfg_vloss_level > floor_val)
            s.bus_mv = 16'($urandom_range(cfg_vloss_level - 1, floor_val));
        else
            s.bus_mv = 16'($urandom_range(16'hFFFF, good_floor));
        s.charge = 10'($urandom_range(1023, floor_val));
        s.temp   = 12'($urandom_range(12'hFFF));
        if (!allow_latch && s.temp == 12'h7FF)
            s.temp = 12'h7FE;
        s.heartbeat = ($urandom_range(9) != 0);
        return s;
    endfunction

    task automatic test_reset_defaults();
        sample_t s;
        set_pace(0, 0);
        s = make_sample(16'd30000, 10'd500, 12'd0, 1'b1);
        s.stamp = 32'h0000_0000;
        send_sample(s);
        s = make_sample(16'hFFFF, 10'd1023, 12'h800, 1'b1);
        s.stamp = 32'hFFFF_FFFF;
        send_sample(s);
        // one missing beat stays under the default limit
        send_sample(make_sample(16'd27499, 10'd301, 12'd259, 1'b0));
        send_sample(make_sample(16'd27500, 10'd300, 12'd259, 1'b1));
        send_sample(make_sample(16'd21001, 10'd101, 12'd259, 1'b0));
        send_sample(make_sample(16'd27499, 10'd301, 12'd0, 1'b1));
        send_sample(make_sample(16'd27500, 10'd301, 12'd0, 1'b1));
    endtask

    task automatic test_ignored_index();
        set_pace(33, 0);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_sample(make_sample(16'd27500, 10'd300, 12'd259, 1'b1));
        send_sample(make_sample(16'd21001, 10'd101, 12'd259, 1'b1));
    endtask

    task automatic test_voltage_loss_runs();
        logic [15:0] run_pattern [12];
        set_pace(33, 33);
        // keep the latching faults out of the way
        write_reg(tfm_pkg::REG_BROWNOUT_LEVEL, 16'd0);
        write_reg(tfm_pkg::REG_OVERHEAT_LEVEL, 16'h07FF);
        write_reg(tfm_pkg::REG_CRITICAL_CHARGE_LEVEL, 16'd0);
        write_reg(tfm_pkg::REG_HEARTBEAT_LIMIT, 16'd255);
        write_reg(tfm_pkg::REG_VOLTAGE_LOSS_LEVEL, 16'd27500);
        write_reg(tfm_pkg::REG_PERSIST_SAMPLES, 16'd3);
        // a good item breaks the low run, a low item breaks the good run
        run_pattern = '{16'd27499, 16'd1, 16'd27500, 16'd27499, 16'd20000, 16'd1,
                        16'd27500, 16'hFFFF, 16'd27499, 16'd27500, 16'd40000, 16'd27500};
        foreach (run_pattern[i])
            send_sample(make_sample(run_pattern[i], 10'd500, 12'd0, 1'b1));

        write_reg(tfm_pkg::REG_PERSIST_SAMPLES, 16'd0);
        send_sample(make_sample(16'd100, 10'd500, 12'd0, 1'b1));
        send_sample(make_sample(16'd30000, 10'd500, 12'd0, 1'b1));

        write_reg(tfm_pkg::REG_VOLTAGE_LOSS_LEVEL, 16'hFFFF);
        write_reg(tfm_pkg::REG_PERSIST_SAMPLES, 16'd1);
        send_sample(make_sample(16'hFFFE, 10'd500, 12'd0, 1'b1));
        send_sample(make_sample(16'hFFFF, 10'd500, 12'd0, 1'b1));

        write_reg(tfm_pkg::REG_VOLTAGE_LOSS_LEVEL, 16'd0);
        send_sample(make_sample(16'd1, 10'd500, 12'd0, 1'b1));
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            unique case (phase)
                0:
                begin
                    set_pace(0, 0);
                    write_reg(tfm_pkg::REG_VOLTAGE_LOSS_LEVEL, 16'hFFFF);
                    write_reg(tfm_pkg::REG_PERSIST_SAMPLES, 16'd255);
                    write_reg(tfm_pkg::REG_LOW_CHARGE_LEVEL, 16'd1023);
                end
                1:
                begin
                    set_pace(65, 0);
                    write_reg(tfm_pkg::REG_VOLTAGE_LOSS_LEVEL, 16'd0);
                    write_reg(tfm_pkg::REG_PERSIST_SAMPLES, 16'd0);
                    write_reg(tfm_pkg::REG_LOW_CHARGE_LEVEL, 16'd0);
                end
                default:
                begin
                    if (phase == 2)
                        set_pace(0, 65);
                    else
                        set_pace(33, 33);
                    write_reg(tfm_pkg::REG_VOLTAGE_LOSS_LEVEL,
                              16'($urandom_range(40000, 10000)));
                    write_reg(tfm_pkg::REG_PERSIST_SAMPLES, 16'($urandom_range(6, 1)));
                    write_reg(tfm_pkg::REG_LOW_CHARGE_LEVEL, 16'($urandom_range(1023)));
                end
            endcase
            burst_left = 0;
            repeat (170)
                send_sample(random_sample(1'b0));
        end
    endtask

    task automatic test_latching_faults();
        set_pace(0, 65);
        write_reg(tfm_pkg::REG_CRITICAL_CHARGE_LEVEL, 16'd1000);
        send_sample(make_sample(16'd30000, 10'd1001, 12'd0, 1'b1));
        send_sample(make_sample(16'd30000, 10'd1000, 12'd0, 1'b1));

        write_reg(tfm_pkg::REG_OVERHEAT_LEVEL, 16'd260);
        send_sample(make_sample(16'd30000, 10'd1023, 12'd259, 1'b1));
        send_sample(make_sample(16'd30000, 10'd1023, 12'd260, 1'b1));

        write_reg(tfm_pkg::REG_BROWNOUT_LEVEL, 16'd21000);
        send_sample(make_sample(16'd21001, 10'd1023, 12'd0, 1'b1));
        send_sample(make_sample(16'd21000, 10'd1023, 12'd0, 1'b1));

        // a beat in between restarts the missing count
        write_reg(tfm_pkg::REG_HEARTBEAT_LIMIT, 16'd3);
        send_sample(make_sample(16'd30000, 10'd500, 12'd0, 1'b1));
        send_sample(make_sample(16'd30000, 10'd500, 12'd0, 1'b0));
        send_sample(make_sample(16'd30000, 10'd500, 12'd0, 1'b0));
        send_sample(make_sample(16'd30000, 10'd500, 12'd0, 1'b1));
        send_sample(make_sample(16'd30000, 10'd500, 12'd0, 1'b0));
        send_sample(make_sample(16'd30000, 10'd500, 12'd0, 1'b0));

        // zero limit acts as one
        write_reg(tfm_pkg::REG_HEARTBEAT_LIMIT, 16'd0);
        send_sample(make_sample(16'd30000, 10'd500, 12'd0, 1'b1));
        send_sample(make_sample(16'd30000, 10'd500, 12'd0, 1'b0));
    endtask

    task automatic test_latched_traffic();
        write_reg(tfm_pkg::REG_BROWNOUT_LEVEL, 16'hFFFF);
        write_reg(tfm_pkg::REG_OVERHEAT_LEVEL, 16'h0800);
        write_reg(tfm_pkg::REG_CRITICAL_CHARGE_LEVEL, 16'd0);
        write_reg(tfm_pkg::REG_HEARTBEAT_LIMIT, 16'd1);
        write_reg(tfm_pkg::REG_VOLTAGE_LOSS_LEVEL, 16'd27500);
        write_reg(tfm_pkg::REG_PERSIST_SAMPLES, 16'd2);
        write_reg(tfm_pkg::REG_LOW_CHARGE_LEVEL, 16'd300);
        for (int phase = 0; phase < 2; phase++)
        begin
            if (phase == 0)
                set_pace(33, 33);
            else
                set_pace(0, 0);
            burst_left = 0;
            repeat (60)
                send_sample(random_sample(1'b1));
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_ignored_index();
        test_voltage_loss_runs();
        test_random_traffic();
        test_latching_faults();
        test_latched_traffic();

        settle();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ telemetry_fault_monitor_top.f @@
hw/rtl/tfm_pkg.sv
hw/rtl/telemetry_fault_monitor_top.sv
verif/telemetry_fault_monitor_top_tb.sv
